FILE: hw/rtl/ppi8_pkg.sv
// Package: shared types and constants of the polyphase 8-tap interpolator.
`timescale 1ns / 1ps
`default_nettype none

package ppi8_pkg;

   localparam int TAPS     = 8;                   // filter taps per phase row
   localparam int TAP_W    = 3;                   // bits of a tap index
   localparam int HALF     = TAPS / 2;            // centre lag of the window
   localparam int SMP_W    = 16;                  // Q1.15 sample / coefficient
   localparam int CNT_W    = 16;                  // coarse sample counter
   localparam int PHCFG_W  = 4;                   // phase_count register
   localparam int LEN_W    = 16;                  // coarse_length register
   localparam int FLEN_W   = 19;                  // fine_length register / fine_index
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 19;
   localparam int PROD_W   = 2 * SMP_W;
   localparam int ACC_W    = PROD_W + TAP_W;      // eight products, no overflow
   localparam int FRAC     = 15;

   // register indices
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COARSE_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FINE_LENGTH   = 2'd2;

   // reset values of the registers
   localparam logic [PHCFG_W-1:0] PHASE_COUNT_RST   = 4'd8;
   localparam logic [LEN_W-1:0]   COARSE_LENGTH_RST = 16'd1024;
   localparam logic [FLEN_W-1:0]  FINE_LENGTH_RST   = 19'd8192;

   typedef enum logic [0:0] {
      REQ_COEF   = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SETUP = 5'b00010,
      ST_POINT = 5'b00100,
      ST_MAC   = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

   typedef struct packed {
      logic [0:0]              req_type;
      logic [TAP_W-1:0]        coef_phase;
      logic [TAP_W-1:0]        coef_tap;
      logic signed [SMP_W-1:0] coef_value;
      logic signed [SMP_W-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] fine_sample;
      logic [FLEN_W-1:0]       fine_index;
      logic                    saturated;
      logic                    run_last;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ppi8_req_if.sv
// Interface: request channel (valid / ready / payload).
`timescale 1ns / 1ps
`default_nettype none

interface ppi8_req_if;
   logic                      valid;
   logic                      ready;
   ppi8_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ppi8_rsp_if.sv
// Interface: result channel (valid / ready / payload).
`timescale 1ns / 1ps
`default_nettype none

interface ppi8_rsp_if;
   logic                      valid;
   logic                      ready;
   ppi8_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/polyphase_8tap_interpolator_top.sv
// Top level: polyphase 8-tap interpolator with one shared multiply-accumulate unit.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Handshake                  Payload
// req_chan   in   valid/ready, both high     req_type, coef_phase, coef_tap, coef_value, sample
// rsp_chan   out  valid/ready, both high     fine_sample, fine_index, saturated, run_last
// csr_*      in   csr_we high                csr_index selects register, csr_wdata
//
// A coefficient load writes the table from the idle state. A coarse sample goes through set-up,
// then one MAC pass per fine sample (one tap a cycle through the single 16x16 multiplier,
// then the coefficient read and product registers drain): up to P fine samples mid-trace;
// the last sample of a trace also flushes the remaining centres (the final centre is sent
// as zero, with no MAC pass).
// A request is taken only while the sequencer is idle. The result register lets the
// sequencer move on while a result waits; it stalls in its final step only when the
// next result is ready and the previous one has not been taken.
// Synchronous reset clears the window, counter, registers and control; the
// coefficient table is not cleared.

module polyphase_8tap_interpolator_top #(
   parameter int MAX_PHASES = 8
) (
   input  wire                                  clock,
   input  wire                                  reset,
   ppi8_req_if.sink                             req_chan,
   ppi8_rsp_if.source                           rsp_chan,
   input  wire                                  csr_we,
   input  wire [ppi8_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [ppi8_pkg::CSR_DAT_W-1:0]        csr_wdata
);

   localparam int PH_W   = $clog2(MAX_PHASES + 1);          // effective phase count
   localparam int K_W    = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;   // phase row
   localparam int ADDR_W = K_W + ppi8_pkg::TAP_W;
   localparam int DEPTH  = MAX_PHASES * ppi8_pkg::TAPS;
   localparam int IDX_W  = ppi8_pkg::CNT_W + PH_W;           // e*P+k before truncation
   localparam int CMP_W  = ((IDX_W > ppi8_pkg::FLEN_W) ? IDX_W : ppi8_pkg::FLEN_W) + 1;
   localparam int L_W    = ppi8_pkg::TAP_W + 1;

   // ---------------------------------------------------------------- registers
   ppi8_pkg::state_type state_ff, state_in;

   logic [ppi8_pkg::PHCFG_W-1:0] phase_cfg_ff, phase_cfg_in;
   logic [ppi8_pkg::LEN_W-1:0]   coarse_len_ff, coarse_len_in;
   logic [ppi8_pkg::FLEN_W-1:0]  fine_len_ff, fine_len_in;

   logic signed [ppi8_pkg::SMP_W-1:0] window_ff [ppi8_pkg::TAPS];
   logic signed [ppi8_pkg::SMP_W-1:0] window_in [ppi8_pkg::TAPS];
   logic [ppi8_pkg::CNT_W-1:0]        cnt_ff, cnt_in;

   // per-request working set
   logic                       last_ff, last_in;     // this sample closes the trace
   logic [PH_W-1:0]            p_ff, p_in;           // effective phase count
   logic [ppi8_pkg::TAP_W-1:0] s_ff, s_in;           // window shift of current centre
   logic [ppi8_pkg::CNT_W-1:0] e_ff, e_in;           // first centre
   logic [IDX_W-1:0]           idx_ff, idx_in;       // current fine index
   logic [K_W-1:0]             k_ff, k_in;           // current phase row
   logic [L_W-1:0]             l_ff, l_in;           // tap issue counter

   // shared MAC pipeline
   logic signed [ppi8_pkg::SMP_W-1:0]  coef_rd_ff;
   logic signed [ppi8_pkg::SMP_W-1:0]  opnd_ff, opnd_in;
   logic signed [ppi8_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [ppi8_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic                               stg1_vld_ff, stg1_vld_in;
   logic                               stg2_vld_ff, stg2_vld_in;

   // result register
   logic                      rsp_vld_ff, rsp_vld_in;
   ppi8_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // coefficient table
   logic signed [ppi8_pkg::SMP_W-1:0] coef_mem [DEPTH];
   logic                              mem_we;
   logic [ADDR_W-1:0]                 mem_waddr;
   logic [ADDR_W-1:0]                 mem_raddr;

   // ---------------------------------------------------------------- helpers
   logic                            req_fire;
   logic                            issue;
   logic [ppi8_pkg::TAP_W:0]        tap_pos;
   logic                            rsp_free;
   logic                            rsp_load;
   logic                            final_pt;
   logic                            idx_over;
   logic                            next_over;
   logic                            sat;
   logic signed [ppi8_pkg::SMP_W-1:0] sat_val;
   logic [ppi8_pkg::LEN_W:0]        len_eff;
   logic [ppi8_pkg::LEN_W:0]        cnt_next;
   logic                            is_last;
   logic [PH_W-1:0]                 p_eff;

   assign req_chan.ready  = (state_ff == ppi8_pkg::ST_IDLE);
   assign req_fire        = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign rsp_free  = !rsp_vld_ff || rsp_chan.ready;
   assign rsp_load  = (state_ff == ppi8_pkg::ST_FIN) && rsp_free;

   // trace end and effective phase count, evaluated on the incoming sample
   assign len_eff  = (coarse_len_ff == '0) ? {1'b1, {ppi8_pkg::LEN_W{1'b0}}}
                                           : {1'b0, coarse_len_ff};
   assign cnt_next = {1'b0, cnt_ff} + 1'b1;
   assign is_last  = (cnt_next >= len_eff);
   assign p_eff    = (32'(phase_cfg_ff) > MAX_PHASES) ? PH_W'(MAX_PHASES)
                                                       : PH_W'(phase_cfg_ff);

   // tap issue and window operand; taps that run past the newest sample are zero
   assign issue   = (state_ff == ppi8_pkg::ST_MAC) && (32'(l_ff) < ppi8_pkg::TAPS);
   assign tap_pos = {1'b0, s_ff} + {1'b0, l_ff[ppi8_pkg::TAP_W-1:0]};

   assign mem_raddr = {k_ff, l_ff[ppi8_pkg::TAP_W-1:0]};
   assign mem_waddr = {K_W'(req_chan.payload.coef_phase), req_chan.payload.coef_tap};

   // end of the request's work: last row of the last centre
   assign final_pt  = (PH_W'(k_ff) == p_ff - 1'b1)
                      && ((32'(s_ff) == ppi8_pkg::HALF) || !last_ff);
   assign idx_over  = (CMP_W'(idx_ff) >= CMP_W'(fine_len_ff));
   assign next_over = ((CMP_W'(idx_ff) + CMP_W'(1)) >= CMP_W'(fine_len_ff));

   // floor shift by 15 then clip to Q1.15
   assign sat = !((&acc_ff[ppi8_pkg::ACC_W-1:2*ppi8_pkg::FRAC])
                  || !(|acc_ff[ppi8_pkg::ACC_W-1:2*ppi8_pkg::FRAC]));
   assign sat_val = sat ? (acc_ff[ppi8_pkg::ACC_W-1] ? 16'sh8000 : 16'sh7FFF)
                        : acc_ff[ppi8_pkg::FRAC+ppi8_pkg::SMP_W-1:ppi8_pkg::FRAC];

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      logic finish;
      finish        = 1'b0;
      state_in      = state_ff;
      phase_cfg_in  = phase_cfg_ff;
      coarse_len_in = coarse_len_ff;
      fine_len_in   = fine_len_ff;
      window_in     = window_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      p_in          = p_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      l_in          = l_ff;
      acc_in        = acc_ff;
      mem_we        = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_chan.ready;

      opnd_in     = tap_pos[ppi8_pkg::TAP_W] ? '0 : window_ff[tap_pos[ppi8_pkg::TAP_W-1:0]];
      prod_in     = coef_rd_ff * opnd_ff;
      stg1_vld_in = issue;
      stg2_vld_in = stg1_vld_ff;
      if (stg2_vld_ff) begin
         acc_in = acc_ff + ppi8_pkg::ACC_W'(prod_ff);
      end

      if (csr_we) begin
         case (csr_index)
            ppi8_pkg::CSR_PHASE_COUNT:   phase_cfg_in  = csr_wdata[ppi8_pkg::PHCFG_W-1:0];
            ppi8_pkg::CSR_COARSE_LENGTH: coarse_len_in = csr_wdata[ppi8_pkg::LEN_W-1:0];
            ppi8_pkg::CSR_FINE_LENGTH:   fine_len_in   = csr_wdata[ppi8_pkg::FLEN_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ppi8_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.payload.req_type == ppi8_pkg::REQ_SAMPLE) begin
                  for (int i = 0; i < ppi8_pkg::TAPS - 1; i++) begin
                     window_in[i] = window_ff[i+1];
                  end
                  window_in[ppi8_pkg::TAPS-1] = req_chan.payload.sample;
                  last_in  = is_last;
                  cnt_in   = is_last ? '0 : cnt_next[ppi8_pkg::CNT_W-1:0];
                  p_in     = p_eff;
                  if (32'(cnt_ff) >= ppi8_pkg::HALF) begin
                     s_in = '0;
                     e_in = cnt_ff - ppi8_pkg::CNT_W'(ppi8_pkg::HALF);
                  end else begin
                     s_in = ppi8_pkg::TAP_W'(ppi8_pkg::HALF) - cnt_ff[ppi8_pkg::TAP_W-1:0];
                     e_in = '0;
                  end
                  state_in = ppi8_pkg::ST_SETUP;
               end else begin
                  mem_we = (32'(req_chan.payload.coef_phase) < MAX_PHASES);
               end
            end
         end
         ppi8_pkg::ST_SETUP: begin
            idx_in = IDX_W'(e_ff) * IDX_W'(p_ff);
            k_in   = '0;
            // a phase count of zero, or mid-trace the first four samples of a trace, produce nothing
            if ((p_ff == '0) || (!last_ff && (s_ff != '0))) begin
               finish = 1'b1;
            end else begin
               state_in = ppi8_pkg::ST_POINT;
            end
         end
         ppi8_pkg::ST_POINT: begin
            acc_in = '0;
            l_in   = '0;
            if (idx_over) begin
               finish = 1'b1;          // indices only grow: nothing more to send
            end else if (last_ff && (32'(s_ff) == ppi8_pkg::HALF)) begin
               state_in = ppi8_pkg::ST_FIN;   // final centre is sent as zero
            end else begin
               state_in = ppi8_pkg::ST_MAC;
            end
         end
         ppi8_pkg::ST_MAC: begin
            if (issue) begin
               l_in = l_ff + 1'b1;
            end else if (!stg1_vld_ff && !stg2_vld_ff) begin
               state_in = ppi8_pkg::ST_FIN;
            end
         end
         ppi8_pkg::ST_FIN: begin
            if (rsp_free) begin
               rsp_vld_in              = 1'b1;
               rsp_data_in.fine_sample = sat_val;
               rsp_data_in.fine_index  = idx_ff[ppi8_pkg::FLEN_W-1:0];
               rsp_data_in.saturated   = sat;
               rsp_data_in.run_last    = final_pt || next_over;
               if (final_pt) begin
                  finish = 1'b1;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ppi8_pkg::ST_POINT;
                  if (PH_W'(k_ff) == p_ff - 1'b1) begin
                     k_in = '0;
                     s_in = s_ff + 1'b1;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ppi8_pkg::ST_IDLE;
         end
      endcase

      if (finish) begin
         state_in = ppi8_pkg::ST_IDLE;
         if (last_ff) begin
            for (int i = 0; i < ppi8_pkg::TAPS; i++) begin
               window_in[i] = '0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ppi8_pkg::ST_IDLE;
         phase_cfg_ff  <= ppi8_pkg::PHASE_COUNT_RST;
         coarse_len_ff <= ppi8_pkg::COARSE_LENGTH_RST;
         fine_len_ff   <= ppi8_pkg::FINE_LENGTH_RST;
         cnt_ff        <= '0;
         stg1_vld_ff   <= 1'b0;
         stg2_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         for (int i = 0; i < ppi8_pkg::TAPS; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         phase_cfg_ff  <= phase_cfg_in;
         coarse_len_ff <= coarse_len_in;
         fine_len_ff   <= fine_len_in;
         cnt_ff        <= cnt_in;
         stg1_vld_ff   <= stg1_vld_in;
         stg2_vld_ff   <= stg2_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
         window_ff     <= window_in;
      end
   end

   // ---------------------------------------------------------------- datapath regs
   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      p_ff        <= p_in;
      s_ff        <= s_in;
      e_ff        <= e_in;
      idx_ff      <= idx_in;
      k_ff        <= k_in;
      l_ff        <= l_in;
      opnd_ff     <= opnd_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // coefficient table, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         coef_mem[mem_waddr] <= req_chan.payload.coef_value;
      end
      coef_rd_ff <= coef_mem[mem_raddr];
   end

   // ---------------------------------------------------------------- assertions
   a_mac_pipe_in_mac : assert property (@(posedge clock) disable iff (reset)
      (stg1_vld_ff || stg2_vld_ff) |-> (state_ff == ppi8_pkg::ST_MAC))
      else $error("MAC pipeline busy outside the MAC state");

   a_tap_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ppi8_pkg::ST_MAC) |-> (32'(l_ff) <= ppi8_pkg::TAPS))
      else $error("tap counter ran past the last tap");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_vld_ff) |-> rsp_chan.ready)
      else $error("pending result overwritten");

   a_shift_bound : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ppi8_pkg::ST_POINT) || (state_ff == ppi8_pkg::ST_FIN))
      |-> (32'(s_ff) <= ppi8_pkg::HALF))
      else $error("window shift beyond the centre lag");

   a_zero_centre_last : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ppi8_pkg::ST_FIN) && (32'(s_ff) == ppi8_pkg::HALF)) |-> last_ff)
      else $error("flush centre reached on a mid-trace sample");

endmodule

`default_nettype wire
